// ===== sv/oaht_pkg.sv =====
// shared types, codes and helpers for the open-addressed hash table
// no dependencies
package oaht_pkg;

   localparam int OAHT_SLOT_COUNT = 1024;
   localparam int OAHT_KEY_CHARS  = 8;

   localparam int KEY_W   = 64;
   localparam int VAL_W   = 31;
   localparam int SIZE_W  = 11;
   localparam int SLOT_W  = 10;
   localparam int CNT_W   = 11;
   localparam int TOTAL_W = 32;
   localparam int CSR_W   = 11;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FOUND = 2'd1;
   localparam logic [1:0] ST_MISS  = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic [1:0] CSR_HASH_MODE  = 2'd0;
   localparam logic [1:0] CSR_PROBE_MODE = 2'd1;
   localparam logic [1:0] CSR_SLOT_LIMIT = 2'd2;

   localparam logic [SIZE_W-1:0] SLOT_LIMIT_RESET = 11'd1021;
   localparam logic [63:0]       DJB2_SEED        = 64'd5381;
   localparam logic [9:0]        STEP_BASE        = 10'd997;

   // remainder unit: dividend lengths in bits
   localparam int MOD_CNT_W = 7;
   localparam logic [MOD_CNT_W-1:0] MOD_WIDE_BITS  = 7'd64;
   localparam logic [MOD_CNT_W-1:0] MOD_SHORT_BITS = 7'd24;

   typedef struct packed {
      logic              start;
      logic              wide;
      logic [63:0]       dividend;
      logic [SIZE_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] rem;
   } mod_rsp_type;

   function automatic logic [KEY_W-1:0] key_mask(input int chars);
      logic [KEY_W-1:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < chars) m = m | (64'hFF << (56 - 8 * i));
      end
      return m;
   endfunction

   // byte / (idx+1) by reciprocal multiply, exact for 8-bit bytes
   function automatic logic [7:0] byte_div(input logic [7:0] c, input logic [2:0] idx);
      logic [16:0] m;
      logic [24:0] p;
      case (idx)
         3'd0:    m = 17'd65536;
         3'd1:    m = 17'd32768;
         3'd2:    m = 17'd21846;
         3'd3:    m = 17'd16384;
         3'd4:    m = 17'd13108;
         3'd5:    m = 17'd10923;
         3'd6:    m = 17'd9363;
         default: m = 17'd8192;
      endcase
      p = 25'(c) * 25'(m);
      return p[23:16];
   endfunction

endpackage

// ===== sv/oaht_req_if.sv =====
// request channel: operation, key and value
// depends on oaht_pkg
interface oaht_req_if import oaht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       operation;
   logic [KEY_W-1:0] key;
   logic [VAL_W-1:0] value;

   modport source(output valid, operation, key, value, input ready);
   modport sink(input valid, operation, key, value, output ready);
endinterface

// ===== sv/oaht_rsp_if.sv =====
// response channel: status, slot, value and counters
// depends on oaht_pkg
interface oaht_rsp_if import oaht_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [SLOT_W-1:0]  slot;
   logic [VAL_W-1:0]   found_value;
   logic [CNT_W-1:0]   probe_count;
   logic [CNT_W-1:0]   element_count;
   logic [TOTAL_W-1:0] total_probes;
   logic               full_flag;

   modport source(output valid, status, slot, found_value, probe_count, element_count,
                  total_probes, full_flag, input ready);
   modport sink(input valid, status, slot, found_value, probe_count, element_count,
                total_probes, full_flag, output ready);
endinterface

// ===== sv/oaht_mod.sv =====
// bit-serial remainder unit, one dividend bit per cycle
// depends on oaht_pkg
module oaht_mod import oaht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type req_in,
   output mod_rsp_type rsp_out
);

   logic                 run_ff;
   logic                 done_ff;
   logic [63:0]          dvd_ff;
   logic [SIZE_W-1:0]    rem_ff;
   logic [MOD_CNT_W-1:0] cnt_ff;
   logic [SIZE_W:0]      trial;
   logic [SIZE_W:0]      rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[63]};
      rem_in = (trial >= {1'b0, req_in.divisor}) ? trial - {1'b0, req_in.divisor} : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && !req_in.start && (cnt_ff == MOD_CNT_W'(1));
         if (req_in.start) begin
            // short dividends sit in the low 24 bits
            dvd_ff <= req_in.wide ? req_in.dividend : {req_in.dividend[23:0], 40'd0};
            cnt_ff <= req_in.wide ? MOD_WIDE_BITS : MOD_SHORT_BITS;
            rem_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            dvd_ff <= {dvd_ff[62:0], 1'b0};
            rem_ff <= rem_in[SIZE_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == MOD_CNT_W'(1)) run_ff <= 1'b0;
         end
      end
   end

   assign rsp_out.done = done_ff;
   assign rsp_out.rem  = rem_ff;

endmodule

// ===== sv/open_addressing_hash_table_top.sv =====
// open-addressed key/value table with tombstones, top level
// depends on oaht_pkg, oaht_req_if, oaht_rsp_if, oaht_mod
//
//   channel | dir | carries
//   req     | in  | operation, key, value
//   rsp     | out | status, slot, found_value, counters, full_flag
//   csr     | in  | we, index, wdata (hash_mode, probe_mode, slot limit)
//
// one operation at a time: an accept state, hashing over the KEY_CHARS key bytes, the
// home-slot remainder of the djb2 (64-bit) or byte-sum (24-bit) dividend, then per probe
// a table read and check plus the next-slot remainder (double hashing, or quadratic via
// a squaring step), and finally the load of the rsp register.
// after reset a clearing pass over all SLOT_COUNT slots runs before the first request.
// a finished beat waits in the rsp register while the next request is taken.
module open_addressing_hash_table_top import oaht_pkg::*; #(
   parameter int SLOT_COUNT = OAHT_SLOT_COUNT,
   parameter int KEY_CHARS  = OAHT_KEY_CHARS
) (
   input  logic             clock,
   input  logic             reset,
   oaht_req_if.sink         req,
   oaht_rsp_if.source       rsp,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int WORD_W = 2 + KEY_W + VAL_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HASH, S_HMOD, S_READ, S_CHECK, S_SQ, S_NMOD, S_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic              hash_mode_ff;
   logic              probe_mode_ff;
   logic [SIZE_W-1:0] slot_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_mode_ff  <= 1'b0;
         probe_mode_ff <= 1'b0;
         slot_limit_ff <= SLOT_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HASH_MODE:  hash_mode_ff  <= csr_wdata[0];
            CSR_PROBE_MODE: probe_mode_ff <= csr_wdata[0];
            CSR_SLOT_LIMIT: slot_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // table memory: used, tombstone, key, value
   logic [WORD_W-1:0] mem [SLOT_COUNT];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic              mem_re;

   // operation context
   logic [AW-1:0]      clr_addr_ff;
   logic [1:0]         op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_sh_ff;
   logic [VAL_W-1:0]   val_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [2:0]         byte_idx_ff;
   logic [63:0]        djb_ff;
   logic [SIZE_W-1:0]  bsum_ff;
   logic [9:0]         ssum_ff;
   logic [SIZE_W-1:0]  home_ff;
   logic [SIZE_W-1:0]  pos_ff;
   logic [CNT_W-1:0]   probes_ff;
   logic [21:0]        sq_ff;
   mod_req_type        mod_req_ff;
   mod_rsp_type        mod_rsp;

   // results and counters
   logic [1:0]         res_status_ff;
   logic [VAL_W-1:0]   res_fval_ff;
   logic               full_ff;
   logic [CNT_W-1:0]   live_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [VAL_W-1:0]   rsp_fval_ff;
   logic [CNT_W-1:0]   rsp_probes_ff;
   logic [CNT_W-1:0]   rsp_live_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_full_ff;

   // combinational helpers
   logic [KEY_W-1:0]   key_masked;
   logic [SIZE_W-1:0]  eff_size;
   logic [7:0]         cur_byte;
   logic [63:0]        djb_in;
   logic [SIZE_W-1:0]  bsum_in;
   logic [9:0]         ssum_in;
   logic               rd_used;
   logic               rd_tomb;
   logic [KEY_W-1:0]   rd_key;
   logic [VAL_W-1:0]   rd_val;
   logic               is_insert;
   logic               hit;
   logic               stop;
   logic               exhausted;
   logic [TOTAL_W:0]   total_sum;
   logic [11:0]        dbl_next;
   logic               mod_start;

   always_comb begin
      key_masked = req.key & key_mask(KEY_CHARS);
      if (slot_limit_ff == '0)
         eff_size = SIZE_W'(1);
      else if (32'(slot_limit_ff) > SLOT_COUNT)
         eff_size = SIZE_W'(SLOT_COUNT);
      else
         eff_size = slot_limit_ff;
      cur_byte  = key_sh_ff[63:56];
      djb_in    = {djb_ff[58:0], 5'd0} + djb_ff + 64'(cur_byte);
      bsum_in   = bsum_ff + SIZE_W'(cur_byte);
      ssum_in   = ssum_ff + 10'(byte_div(cur_byte, byte_idx_ff));
      rd_used   = rd_data_ff[WORD_W-1];
      rd_tomb   = rd_data_ff[WORD_W-2];
      rd_key    = rd_data_ff[VAL_W +: KEY_W];
      rd_val    = rd_data_ff[VAL_W-1:0];
      is_insert = (op_ff == OP_INSERT);
      hit       = rd_used && !rd_tomb && (rd_key == key_ff);
      stop      = !rd_used || (rd_tomb && is_insert);
      exhausted = !stop && !hit && (probes_ff >= size_ff);
      total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(probes_ff);
      // sum of byte/(i+1) stays below 997, so the step needs no reduction
      dbl_next  = 12'(pos_ff) + 12'(STEP_BASE - ssum_ff);
      mod_start = ((state_ff == S_HASH) && (byte_idx_ff == 3'(KEY_CHARS - 1))) ||
                  ((state_ff == S_CHECK) && !stop && !hit && !exhausted && !probe_mode_ff) ||
                  (state_ff == S_SQ);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(pos_ff);
      mem_wdata = '0;
      mem_re    = (state_ff == S_READ);
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
      end else if (state_ff == S_CHECK) begin
         if (is_insert && (stop || hit)) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, 1'b0, key_ff, val_ff};
         end else if (op_ff == OP_REMOVE && hit) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, 1'b1, rd_key, rd_val};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[AW'(pos_ff)];
   end

   oaht_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .req_in  (mod_req_ff),
      .rsp_out (mod_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_addr_ff      <= '0;
         full_ff          <= 1'b0;
         live_ff          <= '0;
         total_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         mod_req_ff.start <= 1'b0;
      end else begin
         mod_req_ff.start   <= mod_start;
         mod_req_ff.divisor <= size_ff;
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == AW'(SLOT_COUNT - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req.valid) begin
                  op_ff         <= req.operation;
                  key_ff        <= key_masked;
                  key_sh_ff     <= key_masked;
                  val_ff        <= req.value;
                  size_ff       <= eff_size;
                  byte_idx_ff   <= '0;
                  djb_ff        <= DJB2_SEED;
                  bsum_ff       <= '0;
                  ssum_ff       <= '0;
                  pos_ff        <= '0;
                  probes_ff     <= '0;
                  res_fval_ff   <= '0;
                  res_status_ff <= (req.operation == OP_INSERT && full_ff) ? ST_FULL : ST_MISS;
                  if (req.operation == OP_INSERT && full_ff) begin
                     state_ff      <= S_DONE;
                  end else if (req.operation == OP_INSERT || req.operation == OP_LOOKUP ||
                               req.operation == OP_REMOVE) begin
                     state_ff <= S_HASH;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_HASH: begin
               djb_ff      <= djb_in;
               bsum_ff     <= bsum_in;
               ssum_ff     <= ssum_in;
               key_sh_ff   <= {key_sh_ff[55:0], 8'd0};
               byte_idx_ff <= byte_idx_ff + 1'b1;
               if (byte_idx_ff == 3'(KEY_CHARS - 1)) begin
                  mod_req_ff.wide     <= !hash_mode_ff;
                  mod_req_ff.dividend <= hash_mode_ff ? 64'(bsum_in) : djb_in;
                  state_ff            <= S_HMOD;
               end
            end
            S_HMOD: begin
               if (mod_rsp.done) begin
                  home_ff   <= mod_rsp.rem;
                  pos_ff    <= mod_rsp.rem;
                  probes_ff <= CNT_W'(1);
                  state_ff  <= S_READ;
               end
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               if (stop || hit) begin
                  state_ff <= S_DONE;
                  case (op_ff)
                     OP_INSERT: begin
                        res_status_ff <= ST_DONE;
                        if (!hit) live_ff <= live_ff + 1'b1;
                        total_ff <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                     end
                     OP_LOOKUP: begin
                        res_status_ff <= hit ? ST_FOUND : ST_MISS;
                        if (hit) res_fval_ff <= rd_val;
                     end
                     default: begin
                        res_status_ff <= hit ? ST_DONE : ST_MISS;
                        if (hit && live_ff != '0) live_ff <= live_ff - 1'b1;
                     end
                  endcase
               end else if (exhausted) begin
                  full_ff       <= 1'b1;
                  res_status_ff <= is_insert ? ST_FULL : ST_MISS;
                  state_ff      <= S_DONE;
               end else if (probe_mode_ff) begin
                  sq_ff    <= 22'(probes_ff) * 22'(probes_ff);
                  state_ff <= S_SQ;
               end else begin
                  mod_req_ff.wide     <= 1'b0;
                  mod_req_ff.dividend <= 64'(dbl_next);
                  state_ff            <= S_NMOD;
               end
            end
            S_SQ: begin
               mod_req_ff.wide     <= 1'b0;
               mod_req_ff.dividend <= 64'(home_ff) + 64'(sq_ff);
               state_ff            <= S_NMOD;
            end
            S_NMOD: begin
               if (mod_rsp.done) begin
                  pos_ff    <= mod_rsp.rem;
                  probes_ff <= probes_ff + 1'b1;
                  state_ff  <= S_READ;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_slot_ff   <= pos_ff[SLOT_W-1:0];
                  rsp_fval_ff   <= res_fval_ff;
                  rsp_probes_ff <= probes_ff;
                  rsp_live_ff   <= live_ff;
                  rsp_total_ff  <= total_ff;
                  rsp_full_ff   <= full_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.slot          = rsp_slot_ff;
   assign rsp.found_value   = rsp_fval_ff;
   assign rsp.probe_count   = rsp_probes_ff;
   assign rsp.element_count = rsp_live_ff;
   assign rsp.total_probes  = rsp_total_ff;
   assign rsp.full_flag     = rsp_full_ff;

   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(full_ff) && !$past(reset) |-> full_ff)
      else $error("full flag dropped");

   a_live_only_on_check: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && live_ff != $past(live_ff) |-> $past(state_ff) == S_CHECK)
      else $error("element count moved outside a probe check");

   a_write_window: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_CHECK))
      else $error("table written outside clear or check");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response beat raised outside done");

endmodule

// ===== dv/oaht_result_checker.sv =====
`timescale 1ns / 1ps
// result checker for the open-addressed hash table: tracks the table in its own
// copy, predicts every response beat and compares it; depends on oaht_pkg and the
// oaht_req_if / oaht_rsp_if interfaces
module oaht_result_checker import oaht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   oaht_req_if              req,
   oaht_rsp_if              rsp,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               mismatches,
   output int               pending,
   output int               responses_checked,
   output logic             full_seen
);

   typedef struct packed {
      logic [1:0]         status;
      logic [SLOT_W-1:0]  slot;
      logic [VAL_W-1:0]   found_value;
      logic [CNT_W-1:0]   probe_count;
      logic [CNT_W-1:0]   element_count;
      logic [TOTAL_W-1:0] total_probes;
      logic               full_flag;
   } table_result_type;

   table_result_type expected_beats[$];

   bit               used_q[OAHT_SLOT_COUNT];
   bit               tomb_q[OAHT_SLOT_COUNT];
   logic [KEY_W-1:0] key_q[OAHT_SLOT_COUNT];
   logic [VAL_W-1:0] val_q[OAHT_SLOT_COUNT];
   bit               full_q;
   int unsigned      live_q;
   logic [31:0]      probe_sum_q;
   bit               hash_sel;
   bit               probe_sel;
   int unsigned      size_reg;

   assign pending   = expected_beats.size();
   assign full_seen = full_q;

   task automatic report(input string field, input longint unsigned got,
                         input longint unsigned want);
      if (mismatches < 20)
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   function automatic int unsigned active_size();
      int unsigned s;
      s = size_reg;
      if (s == 0) s = 1;
      if (s > OAHT_SLOT_COUNT) s = OAHT_SLOT_COUNT;
      return s;
   endfunction

   function automatic int unsigned home_of(input logic [KEY_W-1:0] k, input int unsigned size);
      logic [63:0] h;
      int unsigned bsum;
      h = 64'd5381;
      bsum = 0;
      for (int i = 0; i < 8; i++) begin
         h = (h << 5) + h + 64'(k[63-8*i -: 8]);
         bsum += k[63-8*i -: 8];
      end
      if (hash_sel) return bsum % size;
      return int'(h % 64'(size));
   endfunction

   function automatic int unsigned stride_of(input logic [KEY_W-1:0] k);
      int unsigned s;
      s = 0;
      for (int i = 0; i < 8; i++) s += k[63-8*i -: 8] / (i + 1);
      return 997 - (s % 997);
   endfunction

   // 1 key match, 0 stopping slot, -1 chain exhausted
   function automatic int follow_chain(input logic [KEY_W-1:0] k, input bit for_insert,
                                       output int unsigned pos, output int unsigned probes);
      int unsigned size, home, stride;
      size = active_size();
      home = home_of(k, size);
      stride = stride_of(k);
      pos = home;
      probes = 1;
      while (1) begin
         if (!used_q[pos]) return 0;
         if (tomb_q[pos]) begin
            if (for_insert) return 0;
         end else if (key_q[pos] == k) begin
            return 1;
         end
         if (probes >= size) begin
            full_q = 1;
            return -1;
         end
         if (!probe_sel) pos = (pos + stride) % size;
         else pos = (home + probes * probes) % size;
         probes++;
      end
   endfunction

   function automatic table_result_type predict_op(input logic [1:0] op,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic [VAL_W-1:0] v);
      table_result_type r;
      int unsigned pos, probes;
      int hit;
      r = '0;
      r.status = ST_MISS;
      pos = 0;
      probes = 0;
      if (op == OP_INSERT) begin
         if (full_q) begin
            r.status = ST_FULL;
         end else begin
            hit = follow_chain(k, 1'b1, pos, probes);
            if (hit < 0) begin
               r.status = ST_FULL;
            end else begin
               if (hit == 0) begin
                  used_q[pos] = 1;
                  tomb_q[pos] = 0;
                  key_q[pos] = k;
                  live_q++;
               end
               val_q[pos] = v;
               if (probe_sum_q > 32'hFFFF_FFFF - probes) probe_sum_q = 32'hFFFF_FFFF;
               else probe_sum_q += probes;
               r.status = ST_DONE;
            end
         end
      end else if (op == OP_LOOKUP || op == OP_REMOVE) begin
         hit = follow_chain(k, 1'b0, pos, probes);
         if (hit == 1) begin
            if (op == OP_LOOKUP) begin
               r.status = ST_FOUND;
               r.found_value = val_q[pos];
            end else begin
               tomb_q[pos] = 1;
               if (live_q > 0) live_q--;
               r.status = ST_DONE;
            end
         end
      end
      r.slot = pos[SLOT_W-1:0];
      r.probe_count = probes[CNT_W-1:0];
      r.element_count = live_q[CNT_W-1:0];
      r.total_probes = probe_sum_q;
      r.full_flag = full_q;
      return r;
   endfunction

   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         for (int i = 0; i < OAHT_SLOT_COUNT; i++) begin
            used_q[i] = 0;
            tomb_q[i] = 0;
         end
         full_q = 0;
         live_q = 0;
         probe_sum_q = '0;
         hash_sel = 0;
         probe_sel = 0;
         size_reg = SLOT_LIMIT_RESET;
         expected_beats.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            responses_checked++;
            if (expected_beats.size() == 0) begin
               report("unexpected beat", 1, 0);
            end else begin
               want = expected_beats.pop_front();
               if (rsp.status !== want.status) report("status", rsp.status, want.status);
               if (rsp.slot !== want.slot) report("slot", rsp.slot, want.slot);
               if (rsp.found_value !== want.found_value)
                  report("found_value", rsp.found_value, want.found_value);
               if (rsp.probe_count !== want.probe_count)
                  report("probe_count", rsp.probe_count, want.probe_count);
               if (rsp.element_count !== want.element_count)
                  report("element_count", rsp.element_count, want.element_count);
               if (rsp.total_probes !== want.total_probes)
                  report("total_probes", rsp.total_probes, want.total_probes);
               if (rsp.full_flag !== want.full_flag)
                  report("full_flag", rsp.full_flag, want.full_flag);
            end
         end
         if (req.valid && req.ready)
            expected_beats.push_back(predict_op(req.operation, req.key, req.value));
         if (csr_we) begin
            case (csr_index)
               CSR_HASH_MODE:  hash_sel = csr_wdata[0];
               CSR_PROBE_MODE: probe_sel = csr_wdata[0];
               CSR_SLOT_LIMIT: size_reg = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   initial begin
      mismatches = 0;
      responses_checked = 0;
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// top of the hash table testbench: clock, reset, stimulus, csr phases and verdict
// depends on oaht_pkg, the channel interfaces, the table top and oaht_result_checker
module testbench;
   import oaht_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam logic [1:0] OP_SPARE  = 2'd3;
   localparam int CYCLE_LIMIT = 2000000;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [CSR_W-1:0] csr_wdata;
   int               mismatches, pending, responses_checked;
   logic             full_seen;
   int               cycles;
   bit               hold_rsp;
   bit               no_gaps;
   int               settings_used;
   logic [KEY_W-1:0] key_pool[40];

   oaht_req_if req_if();
   oaht_rsp_if rsp_if();

   open_addressing_hash_table_top dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   oaht_result_checker chk (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending(pending),
      .responses_checked(responses_checked), .full_seen(full_seen)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // response side: random stalls plus one long hold on request
   initial begin
      int r;
      rsp_if.ready = 0;
      @(negedge reset);
      forever begin
         r = $urandom_range(0, 99);
         if (hold_rsp) begin
            rsp_if.ready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (r < 60) begin
            rsp_if.ready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else if (r < 95) begin
            rsp_if.ready <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_if.ready <= 0;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // one request beat; returns just after the edge that took it
   task automatic send_op(input logic [1:0] op, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.operation <= op;
      req_if.key <= k;
      req_if.value <= v;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_if.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [CSR_W-1:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic set_table(input bit hash, input bit probe, input logic [CSR_W-1:0] size);
      wait_idle();
      write_csr(CSR_HASH_MODE, CSR_W'(hash));
      write_csr(CSR_PROBE_MODE, CSR_W'(probe));
      write_csr(CSR_SLOT_LIMIT, size);
      settings_used++;
   endtask

   // mostly pool keys so that hits, overwrites and removes happen often
   task automatic random_ops(input int count, input int pool_len);
      int r;
      logic [1:0] op;
      logic [KEY_W-1:0] k;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45) op = OP_INSERT;
         else if (r < 75) op = OP_LOOKUP;
         else if (r < 95) op = OP_REMOVE;
         else op = OP_SPARE;
         if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
         else k = key_pool[$urandom_range(0, pool_len - 1)];
         send_op(op, k, VAL_W'($urandom));
      end
   endtask

   initial begin
      logic [KEY_W-1:0] ka, kb, kc;
      reset = 1;
      csr_we = 0;
      csr_index = CSR_HASH_MODE;
      csr_wdata = '0;
      req_if.valid = 0;
      req_if.operation = OP_INSERT;
      req_if.key = '0;
      req_if.value = '0;
      hold_rsp = 0;
      no_gaps = 0;
      settings_used = 1;
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = "zebra_01";
      for (int i = 3; i < 40; i++) key_pool[i] = {$urandom, $urandom};
      ka = "apple123";
      kb = "banana!!";
      kc = "cherry_7";
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: hit, miss, overwrite, tombstones, extremes, spare opcode
      send_op(OP_INSERT, ka, '1);
      send_op(OP_LOOKUP, ka, '0);
      send_op(OP_INSERT, ka, '0);
      send_op(OP_LOOKUP, ka, '1);
      send_op(OP_LOOKUP, kb, '0);
      send_op(OP_REMOVE, kb, '0);
      send_op(OP_INSERT, kb, 31'h1234567);
      send_op(OP_REMOVE, ka, '0);
      send_op(OP_LOOKUP, ka, '0);
      send_op(OP_INSERT, kc, 31'h55555555);
      send_op(OP_INSERT, ka, 31'h2AAAAAAA);
      send_op(OP_SPARE, kc, '1);
      send_op(OP_INSERT, key_pool[0], '0);
      send_op(OP_INSERT, key_pool[1], '1);
      send_op(OP_LOOKUP, key_pool[0], '0);
      send_op(OP_LOOKUP, key_pool[1], '0);
      send_op(OP_REMOVE, key_pool[1], '0);
      send_op(OP_LOOKUP, key_pool[1], '0);

      set_table(0, 0, 11'd1021);
      random_ops(60, 40);
      // long receiver hold while requests keep coming
      hold_rsp = 1;
      random_ops(60, 40);
      set_table(1, 1, 11'd1024);
      random_ops(120, 40);
      set_table(1, 0, 11'd2047);
      no_gaps = 1;
      random_ops(100, 40);
      no_gaps = 0;
      set_table(0, 1, 11'd31);
      random_ops(100, 8);
      // tiny tables last: the sticky full flag is reached here
      set_table(0, 0, 11'd5);
      wait_idle();
      write_csr(CSR_SPARE, CSR_W'($urandom));
      random_ops(60, 12);
      set_table(1, 1, 11'd7);
      random_ops(30, 12);
      set_table(0, 0, 11'd0);
      random_ops(20, 12);
      set_table(1, 0, 11'd1);
      random_ops(20, 12);

      wait_idle();
      repeat (200) @(posedge clock);
      $display("covered %0d operations over %0d table settings, full flag %s",
               responses_checked, settings_used, full_seen ? "reached" : "not reached");
      if (mismatches == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/oaht_pkg.sv
sv/oaht_req_if.sv
sv/oaht_rsp_if.sv
sv/oaht_mod.sv
sv/open_addressing_hash_table_top.sv
dv/oaht_result_checker.sv
dv/testbench.sv
